// ----- rtl/sbct_pkg.sv -----
// Shared types and constants for the single-byte code page transcoder.
// Used by the probe cell, the search RAM and the core; depends on nothing.
package sbct_pkg;

  localparam int CP_W       = 21;
  localparam int BYTE_W     = 8;
  localparam int SIZE_W     = 9;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [CP_W-1:0]   UNMAPPED_MARK   = 21'h00FFFF;
  localparam logic [SIZE_W-1:0] SIZE_RESET      = 9'd256;
  localparam logic [BYTE_W-1:0] REPL_BYTE_RESET = 8'd63;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_TABLE_SIZE = 2'd0;
  localparam logic [1:0] REG_USE_REPL   = 2'd1;
  localparam logic [1:0] REG_REPL_BYTE  = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD_DECODE = 2'd0,
    OP_LOAD_SEARCH = 2'd1,
    OP_DECODE      = 2'd2,
    OP_ENCODE      = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNMAPPED = 2'd1,
    ST_REPLACED = 2'd2,
    ST_NOT_REPR = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_CHECK  = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  // Search state handed from one probe cell to the next
  typedef struct packed {
    logic              valid;
    phase_t            phase;
    logic [CP_W-1:0]   key;
    logic [BYTE_W-1:0] found;
    logic              last;
  } probe_ctl_t;

endpackage

// ----- rtl/sbct_search_ram.sv -----
// Sorted code-point-to-byte table: one write port, two registered read ports.
// Depends on sbct_pkg for field widths.
module sbct_search_ram #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [ADDR_W-1:0]             waddr,
  input  logic [sbct_pkg::CP_W-1:0]     wkey,
  input  logic [sbct_pkg::BYTE_W-1:0]   wbyte,
  input  logic [ADDR_W-1:0]             raddr_a,
  input  logic [ADDR_W-1:0]             raddr_b,
  output logic [sbct_pkg::CP_W-1:0]     rkey_a,
  output logic [sbct_pkg::BYTE_W-1:0]   rbyte_a,
  output logic [sbct_pkg::CP_W-1:0]     rkey_b,
  output logic [sbct_pkg::BYTE_W-1:0]   rbyte_b
);

  logic [sbct_pkg::CP_W-1:0]   key_mem  [DEPTH];
  logic [sbct_pkg::BYTE_W-1:0] byte_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr]  <= wkey;
      byte_mem[waddr] <= wbyte;
    end
    rkey_a  <= key_mem[raddr_a];
    rbyte_a <= byte_mem[raddr_a];
    rkey_b  <= key_mem[raddr_b];
    rbyte_b <= byte_mem[raddr_b];
  end

endmodule

// ----- rtl/sbct_probe_cell.sv -----
// One binary-search probe cell: compares the key against the entry read for
// the previous cell, narrows lo/hi and issues the next read. Uses sbct_pkg.
module sbct_probe_cell #(
  parameter int ADDR_W = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          hold,
  input  sbct_pkg::probe_ctl_t          prv_ctl,
  input  logic [ADDR_W-1:0]             prv_lo,
  input  logic [ADDR_W-1:0]             prv_hi,
  input  logic [ADDR_W-1:0]             prv_mid,
  input  logic [sbct_pkg::CP_W-1:0]     rd_key_a,
  input  logic [sbct_pkg::BYTE_W-1:0]   rd_byte_a,
  input  logic [sbct_pkg::CP_W-1:0]     rd_key_b,
  input  logic [sbct_pkg::BYTE_W-1:0]   rd_byte_b,
  output logic                          req,
  output logic [ADDR_W-1:0]             addr_a,
  output logic [ADDR_W-1:0]             addr_b,
  output sbct_pkg::probe_ctl_t          st_ctl,
  output logic [ADDR_W-1:0]             st_lo,
  output logic [ADDR_W-1:0]             st_hi,
  output logic [ADDR_W-1:0]             st_mid
);

  sbct_pkg::probe_ctl_t nxt_ctl;
  logic [ADDR_W-1:0]    nxt_lo;
  logic [ADDR_W-1:0]    nxt_hi;
  logic [ADDR_W-1:0]    nxt_mid;
  logic [ADDR_W-1:0]    span;

  always_comb begin
    nxt_ctl = prv_ctl;
    nxt_lo  = prv_lo;
    nxt_hi  = prv_hi;
    nxt_mid = prv_mid;
    addr_a  = prv_mid;
    addr_b  = prv_lo;
    req     = 1'b0;
    span    = '0;
    if (prv_ctl.valid) begin
      case (prv_ctl.phase)
        sbct_pkg::PH_SEARCH: begin
          if (prv_ctl.key > rd_key_a) begin
            nxt_lo = prv_mid;
          end else if (prv_ctl.key < rd_key_a) begin
            nxt_hi = prv_mid;
          end else begin
            nxt_ctl.found = rd_byte_a;
            nxt_ctl.phase = sbct_pkg::PH_DONE;
          end
          if (nxt_ctl.phase == sbct_pkg::PH_SEARCH) begin
            span = nxt_hi - nxt_lo;
            req  = 1'b1;
            if (span > ADDR_W'(1)) begin
              nxt_mid = nxt_lo + (span >> 1);
              addr_a  = nxt_mid;
            end else begin
              // Loop ends: check hi first, then lo
              nxt_ctl.phase = sbct_pkg::PH_CHECK;
              addr_a        = nxt_hi;
              addr_b        = nxt_lo;
            end
          end
        end
        sbct_pkg::PH_CHECK: begin
          if (prv_ctl.key == rd_key_a) begin
            nxt_ctl.found = rd_byte_a;
          end else if (prv_ctl.key == rd_key_b) begin
            nxt_ctl.found = rd_byte_b;
          end else begin
            nxt_ctl.found = '0;
          end
          nxt_ctl.phase = sbct_pkg::PH_DONE;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_ctl.valid <= 1'b0;
    end else if (!hold) begin
      st_ctl.valid <= nxt_ctl.valid;
    end
    if (!hold) begin
      st_ctl.phase <= nxt_ctl.phase;
      st_ctl.key   <= nxt_ctl.key;
      st_ctl.found <= nxt_ctl.found;
      st_ctl.last  <= nxt_ctl.last;
      st_lo        <= nxt_lo;
      st_hi        <= nxt_hi;
      st_mid       <= nxt_mid;
    end
  end

endmodule

// ----- rtl/single_byte_charset_transcoder_core.sv -----
// Single-byte code page transcoder core: decode table, search RAM, probe chain.
// Depends on sbct_pkg, sbct_search_ram and sbct_probe_cell.
//
// The block converts between an 8-bit code page and 21-bit code points. Load
// items fill the tables: opcode 0 writes decode slot entry_index with
// code_point, opcode 1 writes search slot entry_index with code_point and
// byte_value (slots at or above SEARCH_DEPTH are dropped). The search table
// must be sorted by code point over its first search_table_size entries;
// an unsorted table is searched with the same probe order and may miss.
// Opcode 2 decodes byte_value (0xFFFF in the table means unmapped, status 1).
// Opcode 3 encodes code_point by binary search; a miss, or a found byte of
// zero, gives the replacement byte with status 2 when use_replacement is
// set, else status 3 with out_byte zero. Reading a table slot that was never
// loaded returns unspecified data. A decode item makes one registered read of
// the decode table. An encode item runs through a row of probe cells, at most
// one search-RAM read per cell: ceil(log2(SEARCH_DEPTH-1)) probe cells plus
// one final check cell. Items are taken one at a time; a finished result
// waits in the output register while the next item is accepted. Registers
// must be written over APB only while the block is idle; the block itself
// does not enforce this.
module single_byte_charset_transcoder_core #(
  parameter int SEARCH_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  // item channel
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [1:0]                        opcode,
  input  logic [7:0]                        entry_index,
  input  logic [20:0]                       code_point,
  input  logic [7:0]                        byte_value,
  input  logic                              last_in,
  // result channel
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [20:0]                       out_code_point,
  output logic [7:0]                        out_byte,
  output logic [1:0]                        status,
  output logic                              last_out,
  // APB configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sbct_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [sbct_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [sbct_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int AW         = $clog2(SEARCH_DEPTH);
  // Probe steps needed so the lo/hi window shrinks to one entry apart
  localparam int NUM_PROBES = (SEARCH_DEPTH > 2) ? $clog2(SEARCH_DEPTH - 1) : 1;
  localparam int NUM_CELLS  = NUM_PROBES + 1;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [sbct_pkg::SIZE_W-1:0] search_table_size;
  logic                        use_replacement;
  logic [sbct_pkg::BYTE_W-1:0] replacement_byte;
  logic                        cfg_write;
  logic [1:0]                  cfg_index;

  assign pready    = 1'b1;
  assign cfg_index = paddr[3:2];
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_table_size <= sbct_pkg::SIZE_RESET;
      use_replacement   <= 1'b0;
      replacement_byte  <= sbct_pkg::REPL_BYTE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        sbct_pkg::REG_TABLE_SIZE: search_table_size <= pwdata[sbct_pkg::SIZE_W-1:0];
        sbct_pkg::REG_USE_REPL:   use_replacement   <= pwdata[0];
        sbct_pkg::REG_REPL_BYTE:  replacement_byte  <= pwdata[sbct_pkg::BYTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      sbct_pkg::REG_TABLE_SIZE: prdata = sbct_pkg::APB_DATA_W'(search_table_size);
      sbct_pkg::REG_USE_REPL:   prdata = sbct_pkg::APB_DATA_W'(use_replacement);
      sbct_pkg::REG_REPL_BYTE:  prdata = sbct_pkg::APB_DATA_W'(replacement_byte);
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Item intake
  // ---------------------------------------------------------------------
  logic item_accept;
  logic busy;
  logic acc_load_dec;
  logic acc_load_srch;
  logic acc_decode;
  logic acc_encode;

  assign item_stall    = busy;
  assign item_accept   = item_valid & ~item_stall;
  assign acc_load_dec  = item_accept && (opcode == sbct_pkg::OP_LOAD_DECODE);
  assign acc_load_srch = item_accept && (opcode == sbct_pkg::OP_LOAD_SEARCH);
  assign acc_decode    = item_accept && (opcode == sbct_pkg::OP_DECODE);
  assign acc_encode    = item_accept && (opcode == sbct_pkg::OP_ENCODE);

  // ---------------------------------------------------------------------
  // Decode table: written by opcode 0 load items, read once per decode item
  // ---------------------------------------------------------------------
  logic [sbct_pkg::CP_W-1:0] dec_mem [256];
  logic [sbct_pkg::CP_W-1:0] dec_rdata;
  logic                      dec_pend;
  logic                      dec_last;

  always_ff @(posedge clk) begin
    if (acc_load_dec) begin
      dec_mem[entry_index] <= code_point;
    end
    if (acc_decode) begin
      dec_rdata <= dec_mem[byte_value];
      dec_last  <= last_in;
    end
  end

  // ---------------------------------------------------------------------
  // Search table
  // ---------------------------------------------------------------------
  logic                          srch_we;
  logic [AW-1:0]                 srch_waddr;
  logic [AW-1:0]                 raddr_a;
  logic [AW-1:0]                 raddr_b;
  logic [sbct_pkg::CP_W-1:0]     rd_key_a;
  logic [sbct_pkg::BYTE_W-1:0]   rd_byte_a;
  logic [sbct_pkg::CP_W-1:0]     rd_key_b;
  logic [sbct_pkg::BYTE_W-1:0]   rd_byte_b;

  // Drop search loads beyond the table depth
  assign srch_we    = acc_load_srch && (32'(entry_index) < 32'(SEARCH_DEPTH));
  assign srch_waddr = AW'(entry_index);

  sbct_search_ram #(
    .DEPTH  (SEARCH_DEPTH),
    .ADDR_W (AW)
  ) u_search_ram (
    .clk     (clk),
    .we      (srch_we),
    .waddr   (srch_waddr),
    .wkey    (code_point),
    .wbyte   (byte_value),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rkey_a  (rd_key_a),
    .rbyte_a (rd_byte_a),
    .rkey_b  (rd_key_b),
    .rbyte_b (rd_byte_b)
  );

  // ---------------------------------------------------------------------
  // Search start: clamp the table size and seed the first probe
  // ---------------------------------------------------------------------
  logic [AW-1:0]        hi0;
  logic [AW-1:0]        mid0;
  sbct_pkg::probe_ctl_t start_ctl;
  logic [AW-1:0]        start_hi;
  logic [AW-1:0]        start_mid;

  always_comb begin
    if (search_table_size == '0) begin
      hi0 = '0;
    end else if (32'(search_table_size) > 32'(SEARCH_DEPTH)) begin
      hi0 = AW'(SEARCH_DEPTH - 1);
    end else begin
      hi0 = AW'(search_table_size - sbct_pkg::SIZE_W'(1));
    end
    mid0 = hi0 >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_ctl.valid <= 1'b0;
    end else begin
      start_ctl.valid <= acc_encode;
    end
    if (acc_encode) begin
      start_ctl.phase <= sbct_pkg::PH_SEARCH;
      start_ctl.key   <= code_point;
      start_ctl.found <= '0;
      start_ctl.last  <= last_in;
      start_hi        <= hi0;
      start_mid       <= mid0;
    end
  end

  // ---------------------------------------------------------------------
  // Probe chain: state moves one cell per cycle, at most one RAM read per cell
  // ---------------------------------------------------------------------
  sbct_pkg::probe_ctl_t stg_ctl  [NUM_CELLS+1];
  logic [AW-1:0]        stg_lo   [NUM_CELLS+1];
  logic [AW-1:0]        stg_hi   [NUM_CELLS+1];
  logic [AW-1:0]        stg_mid  [NUM_CELLS+1];
  logic                 cell_req    [NUM_CELLS];
  logic [AW-1:0]        cell_addr_a [NUM_CELLS];
  logic [AW-1:0]        cell_addr_b [NUM_CELLS];
  logic                 result_load;
  logic                 enc_done;
  logic                 enc_hold;

  assign stg_ctl[0] = start_ctl;
  assign stg_lo[0]  = '0;
  assign stg_hi[0]  = start_hi;
  assign stg_mid[0] = start_mid;

  assign enc_done = stg_ctl[NUM_CELLS].valid;
  // Hold the finished search in the last cell until the output register frees
  assign enc_hold = enc_done & ~result_load;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    sbct_probe_cell #(
      .ADDR_W (AW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .hold      ((k == NUM_CELLS - 1) ? enc_hold : 1'b0),
      .prv_ctl   (stg_ctl[k]),
      .prv_lo    (stg_lo[k]),
      .prv_hi    (stg_hi[k]),
      .prv_mid   (stg_mid[k]),
      .rd_key_a  (rd_key_a),
      .rd_byte_a (rd_byte_a),
      .rd_key_b  (rd_key_b),
      .rd_byte_b (rd_byte_b),
      .req       (cell_req[k]),
      .addr_a    (cell_addr_a[k]),
      .addr_b    (cell_addr_b[k]),
      .st_ctl    (stg_ctl[k+1]),
      .st_lo     (stg_lo[k+1]),
      .st_hi     (stg_hi[k+1]),
      .st_mid    (stg_mid[k+1])
    );
  end

  // Only one item is in the chain, so at most one cell asks for a read
  always_comb begin
    raddr_a = mid0;
    raddr_b = '0;
    if (!acc_encode) begin
      for (int k = 0; k < NUM_CELLS; k++) begin
        if (cell_req[k]) begin
          raddr_a = cell_addr_a[k];
          raddr_b = cell_addr_b[k];
        end
      end
    end
  end

  always_comb begin
    busy = dec_pend;
    for (int k = 0; k <= NUM_CELLS; k++) begin
      busy = busy | stg_ctl[k].valid;
    end
  end

  // ---------------------------------------------------------------------
  // Result formatting and output register
  // ---------------------------------------------------------------------
  logic [sbct_pkg::CP_W-1:0]   fmt_cp;
  logic [sbct_pkg::BYTE_W-1:0] fmt_byte;
  sbct_pkg::status_t           fmt_status;
  logic                        fmt_last;

  assign result_load = ~result_valid | ~result_stall;

  always_comb begin
    fmt_cp     = '0;
    fmt_byte   = '0;
    fmt_status = sbct_pkg::ST_OK;
    if (dec_pend) begin
      fmt_last = dec_last;
      if (dec_rdata == sbct_pkg::UNMAPPED_MARK) begin
        fmt_status = sbct_pkg::ST_UNMAPPED;
      end else begin
        fmt_cp = dec_rdata;
      end
    end else begin
      fmt_last = stg_ctl[NUM_CELLS].last;
      // A found byte of zero counts as a miss
      if (stg_ctl[NUM_CELLS].found != '0) begin
        fmt_byte = stg_ctl[NUM_CELLS].found;
      end else if (use_replacement) begin
        fmt_byte   = replacement_byte;
        fmt_status = sbct_pkg::ST_REPLACED;
      end else begin
        fmt_status = sbct_pkg::ST_NOT_REPR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_pend     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (acc_decode) begin
        dec_pend <= 1'b1;
      end else if (result_load) begin
        dec_pend <= 1'b0;
      end
      if (result_load) begin
        result_valid <= dec_pend | enc_done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      out_code_point <= fmt_cp;
      out_byte       <= fmt_byte;
      status         <= fmt_status;
      last_out       <= fmt_last;
    end
  end

endmodule

// ----- test/tb_single_byte_charset_transcoder_core.sv -----
// Self-checking testbench for single_byte_charset_transcoder_core: loads both
// code page tables, runs decode and encode items under several register settings
// and idling patterns, and compares every result with a predictor. Needs sbct_pkg.
`timescale 1ns / 100ps

module tb_single_byte_charset_transcoder_core;

  localparam int SEARCH_DEPTH    = 256;
  localparam int MAX_CP          = 1114111;
  localparam int SETTLE_CYCLES   = 16;
  localparam int LONG_HOLD       = 300;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 130;

  // Mirror of the transcoder: both tables, the registers, and the queue of
  // results still owed by the block, oldest first.
  class code_page_mirror;
    typedef struct {
      logic [20:0] code_pt;
      logic [7:0]  octet;
      logic [1:0]  stat;
      logic        last_flag;
    } xlat_result_t;

    logic [20:0]  decode_entry [256];
    logic [20:0]  search_key [SEARCH_DEPTH];
    logic [7:0]   search_byte [SEARCH_DEPTH];
    logic [8:0]   table_size = sbct_pkg::SIZE_RESET;
    logic         use_repl = 1'b0;
    logic [7:0]   repl_byte = sbct_pkg::REPL_BYTE_RESET;
    xlat_result_t owed [$];
    int           errors = 0;

    // Size register as the search uses it: zero acts as one, clamp to depth.
    function int eff_size();
      int n;
      n = int'(table_size);
      if (n == 0) n = 1;
      if (n > SEARCH_DEPTH) n = SEARCH_DEPTH;
      return n;
    endfunction

    // Same probe order as the hardware; zero means no match.
    function logic [7:0] find_byte(logic [20:0] key);
      int lo, hi, mid;
      lo = 0;
      hi = eff_size() - 1;
      do begin
        mid = lo + (hi - lo) / 2;
        if (key > search_key[mid]) lo = mid;
        else if (key < search_key[mid]) hi = mid;
        else return search_byte[mid];
      end while (lo + 1 < hi);
      if (key == search_key[hi]) return search_byte[hi];
      if (key == search_key[lo]) return search_byte[lo];
      return 8'd0;
    endfunction

    function void accept_item(sbct_pkg::opcode_t op, logic [7:0] idx, logic [20:0] cp,
                              logic [7:0] bv, logic last);
      xlat_result_t r;
      logic [7:0]   hit;
      r.code_pt   = '0;
      r.octet     = '0;
      r.stat      = sbct_pkg::ST_OK;
      r.last_flag = last;
      case (op)
        sbct_pkg::OP_LOAD_DECODE: begin
          decode_entry[idx] = cp;
          return;
        end
        sbct_pkg::OP_LOAD_SEARCH: begin
          search_key[idx]  = cp;
          search_byte[idx] = bv;
          return;
        end
        sbct_pkg::OP_DECODE: begin
          if (decode_entry[bv] == sbct_pkg::UNMAPPED_MARK) r.stat = sbct_pkg::ST_UNMAPPED;
          else r.code_pt = decode_entry[bv];
        end
        default: begin
          hit = find_byte(cp);
          if (hit != 8'd0) begin
            r.octet = hit;
          end else if (use_repl) begin
            r.octet = repl_byte;
            r.stat  = sbct_pkg::ST_REPLACED;
          end else begin
            r.stat = sbct_pkg::ST_NOT_REPR;
          end
        end
      endcase
      owed.push_back(r);
    endfunction

    function void report(string field, int want, int got);
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
    endfunction

    function void check_result(logic [20:0] cp, logic [7:0] ob, logic [1:0] st,
                               logic last);
      xlat_result_t want;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: result with nothing owed, expected none actual cp %0h byte %0h st %0d",
                 $time, cp, ob, st);
        return;
      end
      want = owed.pop_front();
      if (cp !== want.code_pt) report("out_code_point", int'(want.code_pt), int'(cp));
      if (ob !== want.octet) report("out_byte", int'(want.octet), int'(ob));
      if (st !== want.stat) report("status", int'(want.stat), int'(st));
      if (last !== want.last_flag) report("last_out", int'(want.last_flag), int'(last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [1:0]  opcode = sbct_pkg::OP_DECODE;
  logic [7:0]  entry_index = '0;
  logic [20:0] code_point = '0;
  logic [7:0]  byte_value = '0;
  logic        last_in = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [20:0] out_code_point;
  logic [7:0]  out_byte;
  logic [1:0]  status;
  logic        last_out;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [sbct_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [sbct_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [sbct_pkg::APB_DATA_W-1:0] prdata;
  logic        pready;

  code_page_mirror mirror;
  int  sender_gap_pct = 0;
  int  receiver_stall_pct = 0;
  bit  hold_request = 1'b0;
  int  hold_left = 0;
  int  cycle_count = 0;

  // Per-phase settings: size register, replacement, idling on each side.
  int phase_size  [NUM_PHASES] = '{256, 1, 0, 511, 2, 200, 256, 129};
  int phase_repl  [NUM_PHASES] = '{1, 0, 1, 0, 1, 0, 1, 0};
  int phase_gap   [NUM_PHASES] = '{0, 84, 0, 6, 0, 0, 84, 6};
  int phase_stall [NUM_PHASES] = '{0, 0, 84, 6, 0, 84, 0, 6};

  single_byte_charset_transcoder_core #(.SEARCH_DEPTH(SEARCH_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .opcode(opcode),
    .entry_index(entry_index),
    .code_point(code_point),
    .byte_value(byte_value),
    .last_in(last_in),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .out_code_point(out_code_point),
    .out_byte(out_byte),
    .status(status),
    .last_out(last_out),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: give up if the run hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: check whatever was taken at this edge, then decide the stall
  // for the next cycle. A hold request freezes the output for a long stretch
  // so the block backs up and stalls the item channel.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      mirror.check_result(out_code_point, out_byte, status, last_out);
    if (hold_request) begin
      hold_left    = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // APB write: setup cycle, access cycle, then psel drops and the task idles so that
  // back-to-back writes never touch psel twice in one step.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      sbct_pkg::REG_TABLE_SIZE: mirror.table_size = value[8:0];
      sbct_pkg::REG_USE_REPL:   mirror.use_repl   = value[0];
      sbct_pkg::REG_REPL_BYTE:  mirror.repl_byte  = value[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one item, idling first as the phase asks; hold the payload until
  // it is taken, then record it in the mirror.
  task automatic send_item(input sbct_pkg::opcode_t op, input logic [7:0] idx,
                           input logic [20:0] cp, input logic [7:0] bv,
                           input logic last);
    while ($urandom_range(99) < sender_gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid  <= 1'b1;
    opcode      <= op;
    entry_index <= idx;
    code_point  <= cp;
    byte_value  <= bv;
    last_in     <= last;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    mirror.accept_item(op, idx, cp, bv, last);
  endtask

  // Stop offering, wait for every owed result, then let the pipe settle.
  task automatic drain(input int settle);
    item_valid <= 1'b0;
    @(posedge clk);
    while (mirror.owed.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Random mix. Search-table loads mostly keep the keys in order so that
  // encodes exercise real hits; a few drop an arbitrary key in.
  task automatic run_random_items(input int count, input int pause_at);
    int          pick;
    int          slot;
    logic [20:0] cp, lo, hi;
    for (int n = 0; n < count; n++) begin
      if (n == pause_at) drain(0);
      pick = $urandom_range(99);
      slot = $urandom_range(SEARCH_DEPTH - 1);
      if (pick < 12) begin
        cp = ($urandom_range(99) < 20) ? sbct_pkg::UNMAPPED_MARK
                                       : 21'($urandom_range(MAX_CP));
        send_item(sbct_pkg::OP_LOAD_DECODE, 8'(slot), cp, 8'($urandom_range(255)),
                  1'($urandom_range(1)));
      end else if (pick < 24) begin
        lo = (slot == 0) ? 21'd0 : mirror.search_key[slot-1];
        hi = (slot == SEARCH_DEPTH - 1) ? 21'(MAX_CP) : mirror.search_key[slot+1];
        if ($urandom_range(99) < 6) cp = 21'($urandom_range(MAX_CP));
        else if (lo <= hi) cp = 21'($urandom_range(hi, lo));
        else cp = lo;
        send_item(sbct_pkg::OP_LOAD_SEARCH, 8'(slot), cp, 8'($urandom_range(255)),
                  1'($urandom_range(1)));
      end else if (pick < 54) begin
        send_item(sbct_pkg::OP_DECODE, 8'($urandom_range(255)),
                  21'($urandom_range(MAX_CP)),
                  8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        // aim hits inside the searched part of the table
        slot = $urandom_range(mirror.eff_size() - 1);
        cp   = mirror.search_key[slot];
        case ($urandom_range(3))
          0, 1: ;
          2: begin
            if ($urandom_range(1) == 1) cp = (cp >= 21'(MAX_CP)) ? cp : cp + 21'd1;
            else cp = (cp == 21'd0) ? cp : cp - 21'd1;
          end
          default: cp = 21'($urandom_range(MAX_CP));
        endcase
        send_item(sbct_pkg::OP_ENCODE, 8'($urandom_range(255)), cp,
                  8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    logic [20:0] key_acc;
    logic [20:0] cp;
    logic [7:0]  octet;
    mirror = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    write_reg(sbct_pkg::REG_TABLE_SIZE, 32'd256);
    write_reg(sbct_pkg::REG_USE_REPL, 32'd0);
    write_reg(sbct_pkg::REG_REPL_BYTE, 32'd63);

    // Fill every decode slot before any decode; slot 0 holds the lowest code
    // point, slot 255 the highest, and every ninth slot from 4 is unmapped.
    for (int i = 0; i < 256; i++) begin
      if (i == 0) cp = 21'd0;
      else if (i == 255) cp = 21'(MAX_CP);
      else if (i % 9 == 4) cp = sbct_pkg::UNMAPPED_MARK;
      else cp = 21'($urandom_range(MAX_CP));
      send_item(sbct_pkg::OP_LOAD_DECODE, 8'(i), cp, 8'($urandom_range(255)),
                1'($urandom_range(1)));
    end

    // Fill the search table with strictly rising keys; slot 100 maps to byte
    // zero, which the block must treat as a miss.
    key_acc = 21'($urandom_range(200));
    for (int i = 0; i < SEARCH_DEPTH; i++) begin
      key_acc = key_acc + 21'($urandom_range(4000, 1));
      octet   = (i == 100) ? 8'd0 : 8'($urandom_range(255, 1));
      send_item(sbct_pkg::OP_LOAD_SEARCH, 8'(i), key_acc, octet, 1'b0);
    end

    // Directed: field extremes, unmapped byte, lowest and highest keys,
    // misses on both ends, found byte zero, an out-of-order key.
    send_item(sbct_pkg::OP_DECODE, 8'd255, 21'd0, 8'd0, 1'b0);
    send_item(sbct_pkg::OP_DECODE, 8'd0, 21'(MAX_CP), 8'd255, 1'b1);
    send_item(sbct_pkg::OP_DECODE, 8'd0, 21'd0, 8'd4, 1'b0);
    send_item(sbct_pkg::OP_ENCODE, 8'd0, mirror.search_key[0], 8'd0, 1'b1);
    send_item(sbct_pkg::OP_ENCODE, 8'd255, mirror.search_key[255], 8'd255, 1'b0);
    send_item(sbct_pkg::OP_ENCODE, 8'd0, mirror.search_key[77], 8'd0, 1'b0);
    send_item(sbct_pkg::OP_ENCODE, 8'd0, mirror.search_key[100], 8'd0, 1'b1);
    send_item(sbct_pkg::OP_ENCODE, 8'd0, 21'd0, 8'd0, 1'b0);
    send_item(sbct_pkg::OP_ENCODE, 8'd0, 21'(MAX_CP), 8'd0, 1'b0);
    send_item(sbct_pkg::OP_ENCODE, 8'd0, mirror.search_key[50] + 21'd1, 8'd0, 1'b0);
    send_item(sbct_pkg::OP_LOAD_DECODE, 8'd255, 21'h0E0000, 8'd0, 1'b1);
    send_item(sbct_pkg::OP_DECODE, 8'd0, 21'd0, 8'd255, 1'b1);
    send_item(sbct_pkg::OP_LOAD_SEARCH, 8'd255, 21'(MAX_CP), 8'd255, 1'b0);
    send_item(sbct_pkg::OP_ENCODE, 8'd0, 21'(MAX_CP), 8'd0, 1'b0);
    send_item(sbct_pkg::OP_LOAD_SEARCH, 8'd128, 21'd0, 8'd77, 1'b0);
    send_item(sbct_pkg::OP_ENCODE, 8'd0, 21'd0, 8'd0, 1'b0);
    send_item(sbct_pkg::OP_ENCODE, 8'd0, mirror.search_key[129], 8'd0, 1'b1);

    // Replacement on, with the top replacement byte.
    drain(SETTLE_CYCLES);
    write_reg(sbct_pkg::REG_USE_REPL, 32'd1);
    write_reg(sbct_pkg::REG_REPL_BYTE, 32'd255);
    send_item(sbct_pkg::OP_ENCODE, 8'd0, mirror.search_key[100], 8'd0, 1'b0);
    send_item(sbct_pkg::OP_ENCODE, 8'd0, mirror.search_key[254] + 21'd1, 8'd0, 1'b1);
    send_item(sbct_pkg::OP_LOAD_SEARCH, 8'd128, mirror.search_key[127] + 21'd1,
              8'd200, 1'b0);

    // Random phases: reprogram while idle, then run the mix under the
    // phase's idling. Phase 0 also freezes the result side for a long
    // stretch; phase 4 pauses halfway until every result is back.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain(SETTLE_CYCLES);
      write_reg(sbct_pkg::REG_TABLE_SIZE, 32'(phase_size[p]));
      write_reg(sbct_pkg::REG_USE_REPL, 32'(phase_repl[p]));
      write_reg(sbct_pkg::REG_REPL_BYTE, (p == 0) ? 32'd0 : 32'($urandom_range(255)));
      sender_gap_pct     = phase_gap[p];
      receiver_stall_pct = phase_stall[p];
      if (p == 0) hold_request = 1'b1;
      run_random_items(ITEMS_PER_PHASE, (p == 4) ? ITEMS_PER_PHASE / 2 : -1);
    end

    drain(SETTLE_CYCLES);
    if (mirror.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- single_byte_charset_transcoder_core.f -----
rtl/sbct_pkg.sv
rtl/sbct_search_ram.sv
rtl/sbct_probe_cell.sv
rtl/single_byte_charset_transcoder_core.sv
test/tb_single_byte_charset_transcoder_core.sv
